/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the tap rhythm record/replay RTL.
// Expects clk_i and rst_ni in the scope of the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset.
`define TRRR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when ante holds, cons must hold in the same cycle.
`define TRRR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/trrr_pkg.sv */
// Shared types and constants for the tap rhythm record/replay block.
// No dependencies.
package trrr_pkg;

  localparam int unsigned CNT_W = 16;
  localparam logic [CNT_W-1:0] IDLE_TIMEOUT_RST = 16'd300;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_RECORD = 2'd1,
    MODE_REPLAY = 2'd2
  } mode_e;

  // One result beat.
  typedef struct packed {
    logic  red;
    logic  green;
    mode_e mode;
  } result_t;

endpackage

/* hw/rtl/tap_rhythm_record_replay_core.sv */
// Top level of the tap rhythm recorder/replayer.
// Depends on trrr_pkg, trrr_ram, trrr_ctrl and trrr_outq.
//
// Usage:
//   Input channel: one beat per timer tick, carrying button_pressed_i, handshake
//   in_valid_i / in_stall_o. Output channel: one result beat per tick (red_led_o,
//   green_led_o, mode_now_o), handshake out_valid_o / out_stall_i.
//   idle_timeout is written through cfg_we_i / cfg_wdata_i; the user must write it only while idle (not enforced).
// Throughput and forwarding:
//   A tick is processed in the cycle it is accepted and its result is registered in
//   the output buffer; one tick per cycle sustained while the output is not stalled.
//   The interval RAM read data is registered; the reloaded interval is bypassed into
//   the tick counter in the cycle it returns, so a following tick never waits. A
//   second write from the same tick goes in the next cycle, forwarded to any read then.
// Reset:
//   Mode idle, red on, green off, idle_timeout = 300. The interval RAM is not
//   cleared (no clearing pass); replay only reads slots written in the same take.
// Back-pressure:
//   Results sit in a two-entry buffer. in_stall_o rises only when both entries
//   are held, so a tick is still taken while one result waits.
module tap_rhythm_record_replay_core #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [trrr_pkg::CNT_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       button_pressed_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       red_led_o,
  output logic                       green_led_o,
  output logic [1:0]                 mode_now_o
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned CW = trrr_pkg::CNT_W;

  logic [CW-1:0]     idle_timeout_q;
  logic              accept;
  trrr_pkg::result_t result, out_data;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [CW-1:0] ram_wdata, ram_rdata;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_timeout_q <= trrr_pkg::IDLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      idle_timeout_q <= cfg_wdata_i;
    end
  end

  assign accept = in_valid_i & ~in_stall_o;

  trrr_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .level_i        (button_pressed_i),
    .idle_timeout_i (idle_timeout_q),
    .result_o       (result),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata)
  );

  // interval store
  trrr_ram #(
    .WIDTH (CW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  trrr_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .full_o  (in_stall_o),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data)
  );

  assign red_led_o   = out_data.red;
  assign green_led_o = out_data.green;
  assign mode_now_o  = 2'(out_data.mode);

endmodule

/* hw/rtl/trrr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module trrr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/trrr_ctrl.sv */
// Tick processor: mode, counters and read-modify-write of the interval RAM.
// Depends on trrr_pkg and assert_macros.svh; RAM sits outside in the top level.
`include "assert_macros.svh"

module trrr_ctrl #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic                             level_i,
  input  logic [trrr_pkg::CNT_W-1:0]       idle_timeout_i,
  output trrr_pkg::result_t                result_o,
  output logic                             ram_we_o,
  output logic [$clog2(SLOTS)-1:0]         ram_waddr_o,
  output logic [trrr_pkg::CNT_W-1:0]       ram_wdata_o,
  output logic [$clog2(SLOTS)-1:0]         ram_raddr_o,
  input  logic [trrr_pkg::CNT_W-1:0]       ram_rdata_i
);

  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam int unsigned CW = trrr_pkg::CNT_W;
  localparam logic [SW-1:0] LAST  = SW'(SLOTS - 1);
  localparam logic [SW-1:0] ONE_S = SW'(1);

  trrr_pkg::mode_e mode_q, mode_d;
  logic          prev_q, prev_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_cur, ld_val;
  logic [SW-1:0] ws_q, ws_d;
  logic [SW-1:0] play_q, play_d;
  logic          red_q, red_d;
  logic          green_q, green_d;

  // pending load of the tick counter from the RAM
  logic          ld, ld_pend_q;
  logic [AW-1:0] ld_addr;
  logic          fwd_hit_d, fwd_hit_q;
  logic [CW-1:0] fwd_data_d, fwd_data_q;

  // edge write (w1) and end-of-record write (w2)
  logic          w1, w2;
  logic [AW-1:0] w1_addr, w2_addr;
  logic [CW-1:0] w1_data, w2_data;
  logic          full, tmo;

  // deferred second write
  logic          pw_vld_q;
  logic [AW-1:0] pw_addr_q;
  logic [CW-1:0] pw_data_q;

  // shadow of slot 0, needed within the tick that ends recording
  logic [CW-1:0] first_q;

  assign ld_val  = fwd_hit_q ? fwd_data_q : ram_rdata_i;
  assign cnt_cur = ld_pend_q ? ld_val : cnt_q;

  always_comb begin
    mode_d  = mode_q;
    prev_d  = prev_q;
    cnt_d   = cnt_cur;
    ws_d    = ws_q;
    play_d  = play_q;
    red_d   = red_q;
    green_d = green_q;
    w1      = 1'b0;
    w1_addr = '0;
    w1_data = '0;
    w2      = 1'b0;
    w2_addr = '0;
    w2_data = '0;
    ld      = 1'b0;
    ld_addr = '0;
    full    = 1'b0;
    tmo     = 1'b0;
    if (accept_i) begin
      if (mode_d == trrr_pkg::MODE_IDLE && prev_d != level_i) begin
        play_d  = '0;
        ws_d    = '0;
        cnt_d   = '0;
        green_d = 1'b1;
        prev_d  = level_i;
        mode_d  = trrr_pkg::MODE_RECORD;
      end

      if (mode_d == trrr_pkg::MODE_RECORD) begin
        cnt_d = cnt_d + CW'(1);
        red_d = 1'b1;
        if (prev_d != level_i && ws_d < LAST) begin
          w1      = 1'b1;
          w1_addr = ws_d[AW-1:0];
          w1_data = cnt_d;
          cnt_d   = '0;
          green_d = ~green_d;
          prev_d  = level_i;
          ws_d    = ws_d + ONE_S;
        end
        full = (ws_d >= LAST);
        tmo  = !full && (cnt_d >= idle_timeout_i) && (ws_d != '0) && !level_i;
        if (full || tmo) begin
          // a full store gets no end-of-record write; only a timeout writes the last interval
          if (tmo) begin
            w2      = 1'b1;
            w2_addr = ws_d[AW-1:0];
            w2_data = cnt_d;
          end
          ws_d    = ws_d + ONE_S;
          cnt_d   = (w1 && w1_addr == '0) ? w1_data : first_q;
          green_d = 1'b1;
          mode_d  = trrr_pkg::MODE_REPLAY;
        end
      end

      if (mode_d == trrr_pkg::MODE_REPLAY && play_d < ws_d) begin
        cnt_d = cnt_d - CW'(1);
        red_d = 1'b0;
        if (cnt_d == '0) begin
          green_d = ~green_d;
          play_d  = play_d + ONE_S;
          if (play_d < ws_d && play_d < LAST) begin
            ld      = 1'b1;
            ld_addr = play_d[AW-1:0];
          end else begin
            cnt_d = '0;
          end
        end
        if (play_d == ws_d || play_d >= LAST) begin
          mode_d  = trrr_pkg::MODE_IDLE;
          red_d   = 1'b1;
          green_d = 1'b0;
        end
      end
    end
  end

  // forward any write that lands while the load is in flight
  always_comb begin
    fwd_hit_d  = 1'b0;
    fwd_data_d = '0;
    if (w2 && w2_addr == ld_addr) begin
      fwd_hit_d  = 1'b1;
      fwd_data_d = w2_data;
    end else if (w1 && w1_addr == ld_addr) begin
      fwd_hit_d  = 1'b1;
      fwd_data_d = w1_data;
    end else if (pw_vld_q && pw_addr_q == ld_addr) begin
      fwd_hit_d  = 1'b1;
      fwd_data_d = pw_data_q;
    end
  end

  // write port: deferred write first, then the edge write, then the end write
  assign ram_we_o = pw_vld_q | w1 | w2;
  always_comb begin
    if (pw_vld_q) begin
      ram_waddr_o = pw_addr_q;
      ram_wdata_o = pw_data_q;
    end else if (w1) begin
      ram_waddr_o = w1_addr;
      ram_wdata_o = w1_data;
    end else begin
      ram_waddr_o = w2_addr;
      ram_wdata_o = w2_data;
    end
  end

  assign ram_raddr_o = ld_addr;

  assign result_o.red   = red_d;
  assign result_o.green = green_d;
  assign result_o.mode  = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= trrr_pkg::MODE_IDLE;
      prev_q    <= 1'b0;
      cnt_q     <= '0;
      ws_q      <= '0;
      play_q    <= '0;
      red_q     <= 1'b1;
      green_q   <= 1'b0;
      ld_pend_q <= 1'b0;
      pw_vld_q  <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      prev_q    <= prev_d;
      cnt_q     <= cnt_d;
      ws_q      <= ws_d;
      play_q    <= play_d;
      red_q     <= red_d;
      green_q   <= green_d;
      ld_pend_q <= ld;
      pw_vld_q  <= w1 & w2;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_hit_q  <= fwd_hit_d;
    fwd_data_q <= fwd_data_d;
    pw_addr_q  <= w2_addr;
    pw_data_q  <= w2_data;
    if (w1 && w1_addr == '0) begin
      first_q <= w1_data;
    end
  end

  `TRRR_ASSERT_IMP(a_no_wr_collide, pw_vld_q, !(w1 || w2), "deferred write collides with new write")
  `TRRR_ASSERT_IMP(a_ld_follows_beat, ld_pend_q, $past(accept_i), "counter load without a beat")
  `TRRR_ASSERT_IMP(a_replay_has_slots, mode_q == trrr_pkg::MODE_REPLAY, ws_q != '0,
                   "replay with empty store")

endmodule

/* hw/rtl/trrr_outq.sv */
// Two-entry result buffer between the tick processor and the output channel.
// Depends on trrr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trrr_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trrr_pkg::result_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              stall_i,
  output trrr_pkg::result_t data_o
);

  trrr_pkg::result_t entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign pop     = valid_o & ~stall_i;
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  `TRRR_ASSERT_IMP(a_no_push_full, push_i, cnt_q != 2'd2, "push into full result buffer")

endmodule
